// ===== src/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every rising edge of clk outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// check an implication at every rising edge of clk outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== src/swdh_pkg.sv =====
// ============================================================================
// SWD host package
// Request and result types, sequencer state, phase and status codes.
// ============================================================================
package swdh_pkg;

	typedef struct packed {
		logic        cmd_valid;
		logic [1:0]  opcode;
		logic [7:0]  request_header;
		logic [31:0] write_data;
		logic [7:0]  retry_limit;
		logic        swdio_sample;
	} swdh_in_t;

	typedef struct packed {
		logic        swdio_out;
		logic        swdio_drive;
		logic        clock_pulse;
		logic        busy_res;
		logic        done_res;
		logic [2:0]  status;
		logic [31:0] read_data;
	} swdh_out_t;

	typedef struct packed {
		logic [3:0]  phase;
		logic [5:0]  bit_count;
		logic [31:0] shift_word;
		logic [7:0]  header_hold;
		logic [31:0] write_hold;
		logic [2:0]  ack_hold;
		logic [7:0]  attempts_left;
		logic [1:0]  command_kind;
		logic [31:0] result_word;
	} swdh_state_t;

	localparam logic [3:0] PH_IDLE   = 4'd0;
	localparam logic [3:0] PH_ONES_A = 4'd1;
	localparam logic [3:0] PH_SELECT = 4'd2;
	localparam logic [3:0] PH_ZEROS  = 4'd3;
	localparam logic [3:0] PH_ONES_B = 4'd4;
	localparam logic [3:0] PH_HEADER = 4'd5;
	localparam logic [3:0] PH_ACK    = 4'd6;
	localparam logic [3:0] PH_RDATA  = 4'd7;
	localparam logic [3:0] PH_RPAR   = 4'd8;
	localparam logic [3:0] PH_TURN   = 4'd9;
	localparam logic [3:0] PH_WDATA  = 4'd10;
	localparam logic [3:0] PH_WPAR   = 4'd11;
	localparam logic [3:0] PH_DRAIN  = 4'd12;

	localparam logic [1:0] OP_XFER       = 2'd0;
	localparam logic [1:0] OP_LINE_RESET = 2'd1;
	localparam logic [1:0] OP_CONNECT    = 2'd2;
	localparam logic [1:0] OP_DISCONNECT = 2'd3;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_WAIT   = 3'd1;
	localparam logic [2:0] ST_FAULT  = 3'd2;
	localparam logic [2:0] ST_PARITY = 3'd3;
	localparam logic [2:0] ST_NOACK  = 3'd4;

	localparam logic [2:0] ACK_OK    = 3'd1;
	localparam logic [2:0] ACK_WAIT  = 3'd2;
	localparam logic [2:0] ACK_FAULT = 3'd4;

	localparam logic [7:0]  IDCODE_REQ  = 8'hA5;
	localparam logic [15:0] SEL_TO_SWD  = 16'hE79E;
	localparam logic [15:0] SEL_TO_JTAG = 16'hE73C;

	localparam logic [6:0] LEN_ONES   = 7'd56;
	localparam logic [6:0] LEN_SELECT = 7'd16;
	localparam logic [6:0] LEN_ZEROS  = 7'd8;
	localparam logic [6:0] LEN_HEADER = 7'd8;
	localparam logic [6:0] LEN_ACK    = 7'd4;
	localparam logic [6:0] LEN_DATA   = 7'd32;
	localparam logic [6:0] LEN_RPAR   = 7'd2;
	localparam logic [6:0] LEN_TURN   = 7'd1;
	localparam logic [6:0] LEN_WPAR   = 7'd8;
	localparam logic [6:0] LEN_DRAIN  = 7'd34;

endpackage

// ===== src/swdh_step.sv =====
// ============================================================================
// SWD host period step
// Next sequencer state and line levels for one SWCLK period.
// ============================================================================
module swdh_step
	import swdh_pkg::*;
(
	input  swdh_state_t st,
	input  swdh_in_t    item,
	output swdh_state_t st_next,
	output swdh_out_t   res
);

	swdh_state_t nxt;
	logic [5:0]  bc;
	logic [6:0]  cnt_inc;
	logic [6:0]  len;
	logic        last;
	logic        active;
	logic        ea;
	logic [2:0]  ea_st;

	always_comb begin
		nxt     = st;
		res     = '0;
		bc      = '0;
		cnt_inc = '0;
		len     = LEN_TURN;
		last    = 1'b0;
		ea      = 1'b0;
		ea_st   = ST_OK;
		active  = (st.phase != PH_IDLE) || item.cmd_valid;

		if (st.phase == PH_IDLE && item.cmd_valid) begin
			nxt.command_kind = item.opcode;
			nxt.result_word  = '0;
			nxt.ack_hold     = '0;
			nxt.shift_word   = '0;
			nxt.bit_count    = '0;
			if (item.opcode == OP_XFER) begin
				nxt.header_hold   = item.request_header;
				nxt.write_hold    = item.write_data;
				nxt.attempts_left = (item.retry_limit != 8'd0) ? item.retry_limit : 8'd1;
				nxt.phase         = PH_HEADER;
			end else begin
				nxt.header_hold   = IDCODE_REQ;
				nxt.write_hold    = '0;
				nxt.attempts_left = 8'd1;
				nxt.phase         = PH_ONES_A;
			end
		end

		bc      = nxt.bit_count;
		cnt_inc = {1'b0, bc} + 7'd1;

		unique case (nxt.phase)
			PH_ONES_A, PH_ONES_B: len = LEN_ONES;
			PH_SELECT:            len = LEN_SELECT;
			PH_ZEROS:             len = LEN_ZEROS;
			PH_HEADER:            len = LEN_HEADER;
			PH_ACK:               len = LEN_ACK;
			PH_RDATA, PH_WDATA:   len = LEN_DATA;
			PH_RPAR:              len = LEN_RPAR;
			PH_WPAR:              len = LEN_WPAR;
			PH_DRAIN:             len = LEN_DRAIN;
			default:              len = LEN_TURN;
		endcase
		last = (cnt_inc >= len);

		if (active) begin
			res.clock_pulse = 1'b1;
			res.busy_res    = 1'b1;
			nxt.bit_count   = last ? 6'd0 : cnt_inc[5:0];

			unique case (nxt.phase)
				PH_ONES_A: begin
					res.swdio_out   = 1'b1;
					res.swdio_drive = 1'b1;
					if (last) begin
						if (nxt.command_kind == OP_LINE_RESET) begin
							nxt.phase = PH_ZEROS;
						end else begin
							nxt.shift_word = {16'h0, (nxt.command_kind == OP_CONNECT) ?
								SEL_TO_SWD : SEL_TO_JTAG};
							nxt.phase = PH_SELECT;
						end
					end
				end
				PH_SELECT: begin
					res.swdio_out   = nxt.shift_word[bc[3:0]];
					res.swdio_drive = 1'b1;
					if (last) begin
						if (nxt.command_kind == OP_CONNECT) begin
							nxt.command_kind = OP_LINE_RESET;
							nxt.phase        = PH_ONES_A;
						end else begin
							nxt.phase = PH_ONES_B;
						end
					end
				end
				PH_ZEROS: begin
					res.swdio_drive = 1'b1;
					if (last) begin
						nxt.phase = PH_HEADER;
					end
				end
				PH_ONES_B: begin
					res.swdio_out   = 1'b1;
					res.swdio_drive = 1'b1;
					if (last) begin
						res.done_res = 1'b1;
						res.status   = ST_OK;
						nxt.phase    = PH_IDLE;
					end
				end
				PH_HEADER: begin
					res.swdio_out   = nxt.header_hold[bc[2:0]];
					res.swdio_drive = 1'b1;
					if (last) begin
						nxt.phase = PH_ACK;
					end
				end
				PH_ACK: begin
					if (bc == 6'd0) begin
						nxt.ack_hold = '0;
					end else begin
						nxt.ack_hold = nxt.ack_hold |
							(3'({2'b00, item.swdio_sample}) << (bc[1:0] - 2'd1));
					end
					if (last) begin
						if (nxt.ack_hold == ACK_OK) begin
							if (nxt.header_hold[2]) begin
								nxt.shift_word = '0;
								nxt.phase      = PH_RDATA;
							end else begin
								nxt.phase = PH_TURN;
							end
						end else if (nxt.ack_hold == ACK_WAIT || nxt.ack_hold == ACK_FAULT) begin
							nxt.phase = PH_TURN;
						end else begin
							nxt.phase = PH_DRAIN;
						end
					end
				end
				PH_RDATA: begin
					nxt.shift_word[bc[4:0]] = nxt.shift_word[bc[4:0]] | item.swdio_sample;
					if (last) begin
						nxt.phase = PH_RPAR;
					end
				end
				PH_RPAR: begin
					if (bc == 6'd0) begin
						nxt.ack_hold = (item.swdio_sample ^ (^nxt.shift_word)) ? 3'd0 : ACK_OK;
					end
					if (last) begin
						nxt.result_word = nxt.shift_word;
						res.done_res    = 1'b1;
						res.status      = (nxt.ack_hold == ACK_OK) ? ST_OK : ST_PARITY;
						nxt.phase       = PH_IDLE;
					end
				end
				PH_TURN: begin
					if (nxt.ack_hold == ACK_OK) begin
						nxt.phase = PH_WDATA;
					end else begin
						ea    = 1'b1;
						ea_st = (nxt.ack_hold == ACK_WAIT) ? ST_WAIT : ST_FAULT;
					end
				end
				PH_WDATA: begin
					res.swdio_out   = nxt.write_hold[bc[4:0]];
					res.swdio_drive = 1'b1;
					if (last) begin
						nxt.phase = PH_WPAR;
					end
				end
				PH_WPAR: begin
					res.swdio_out   = (bc == 6'd0) ? (^nxt.write_hold) : 1'b0;
					res.swdio_drive = 1'b1;
					if (last) begin
						res.done_res = 1'b1;
						res.status   = ST_OK;
						nxt.phase    = PH_IDLE;
					end
				end
				PH_DRAIN: begin
					if (last) begin
						ea    = 1'b1;
						ea_st = ST_NOACK;
					end
				end
				default: begin
					res.done_res = 1'b1;
					res.status   = ST_NOACK;
					nxt.phase    = PH_IDLE;
				end
			endcase

			if (ea) begin
				if (ea_st == ST_WAIT && nxt.attempts_left > 8'd1) begin
					nxt.attempts_left = nxt.attempts_left - 8'd1;
					nxt.phase         = PH_HEADER;
				end else begin
					res.done_res = 1'b1;
					res.status   = ea_st;
					nxt.phase    = PH_IDLE;
				end
			end

			if (res.done_res) begin
				res.read_data = nxt.result_word;
			end
		end
	end

	assign st_next = nxt;

endmodule

// ===== src/swd_host_transaction_engine_core.sv =====
// ============================================================================
// SWD host transaction engine
// One request per SWCLK period; drives and samples SWDIO for transactions,
// line reset, connect and disconnect sequences.
// ============================================================================
//  channel   signals                             carries
//  period    period_valid / period_stall / period  cmd fields and sampled SWDIO
//  result    result_valid / result_stall / result  line levels, done, status, data
//
//  One request is accepted per cycle while period_stall is low; it is held in the
//  request stage and then registered into the result register. The sequencer state
//  advances in the cycle the registered request moves into the result register,
//  through one pass of the step logic. Reset clears control state and returns the
//  sequencer to idle. A stalled result holds the request stage and raises period_stall.
// ============================================================================
`include "assert_macros.svh"

module swd_host_transaction_engine_core
	import swdh_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      period_valid,
	output logic      period_stall,
	input  swdh_in_t  period,
	output logic      result_valid,
	input  logic      result_stall,
	output swdh_out_t result
);

	logic        valid_s1;
	swdh_in_t    item_s1;
	logic        out_valid_q;
	swdh_out_t   result_q;
	swdh_state_t st_q;
	swdh_state_t st_next;
	swdh_out_t   step_res;
	logic        out_load;
	logic        step_en;

	assign out_load     = !out_valid_q || !result_stall;
	assign step_en      = valid_s1 && out_load;
	assign period_stall = valid_s1 && !out_load;
	assign result_valid = out_valid_q;
	assign result       = result_q;

	swdh_step u_step (
		.st      (st_q),
		.item    (item_s1),
		.st_next (st_next),
		.res     (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!period_stall) begin
			valid_s1 <= period_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (period_valid && !period_stall) begin
			item_s1 <= period;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			st_q        <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= valid_s1;
			end
			if (step_en) begin
				st_q <= st_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			result_q <= step_res;
		end
	end

	`ASSERT_IMPL(a_stall_src, period_stall, result_valid && result_stall, "stall without held result")
	`ASSERT_IMPL(a_done_idle, step_en && step_res.done_res, st_next.phase == PH_IDLE, "done without idle")
	`ASSERT_CLK(a_count_range, st_q.bit_count < 6'd56, "bit count out of range")
	`ASSERT_IMPL(a_attempts, st_q.phase == PH_HEADER, st_q.attempts_left != 8'd0, "no attempts left in header")

endmodule

// ===== test/swd_host_transaction_engine_core_tb.sv =====
// ============================================================================
// SWD host transaction engine testbench
// Drives one request per SWCLK period and acts as the SWD target on the
// sampled SWDIO bit, answering acks, read data and parity from a cycle-exact
// model of the sequencer. Each result is checked field by field in order.
// ============================================================================
module swd_host_transaction_engine_core_tb;
	import swdh_pkg::*;

	localparam int unsigned QUIET_LIMIT = 3000;
	localparam int unsigned ITEM_TARGET = 800;

	class swd_period_scoreboard;
		logic [3:0]  seq_phase;
		logic [5:0]  bit_idx;
		logic [31:0] shreg;
		logic [7:0]  hdr_q;
		logic [31:0] wdata_q;
		logic [2:0]  ack_q;
		logic [7:0]  tries_left;
		logic [1:0]  kind_q;
		logic [31:0] rdata_q;
		logic        fin;
		logic [2:0]  fin_st;
		swdh_out_t   line_results_due[$];
		int unsigned errors;

		function new();
			seq_phase = PH_IDLE;
			bit_idx = '0;
			shreg = '0;
			hdr_q = '0;
			wdata_q = '0;
			ack_q = '0;
			tries_left = '0;
			kind_q = '0;
			rdata_q = '0;
			errors = 0;
		endfunction

		function int unsigned pending();
			return line_results_due.size();
		endfunction

		function void enter(logic [3:0] ph);
			seq_phase = ph;
			bit_idx = '0;
		endfunction

		function void finish_cmd(logic [2:0] st);
			fin = 1'b1;
			fin_st = st;
			enter(PH_IDLE);
		endfunction

		function void end_attempt(logic [2:0] st);
			if (st == ST_WAIT && tries_left > 8'd1) begin
				tries_left = tries_left - 8'd1;
				enter(PH_HEADER);
			end else begin
				finish_cmd(st);
			end
		endfunction

		function logic span_done(logic [6:0] len);
			if ({1'b0, bit_idx} + 7'd1 >= len)
				return 1'b1;
			bit_idx = bit_idx + 6'd1;
			return 1'b0;
		endfunction

		function swdh_out_t advance_sequencer(swdh_in_t r);
			swdh_out_t  o;
			logic [5:0] bc;
			o = '0;
			fin = 1'b0;
			fin_st = ST_OK;
			if (seq_phase == PH_IDLE) begin
				if (!r.cmd_valid)
					return o;
				kind_q = r.opcode;
				rdata_q = '0;
				ack_q = '0;
				shreg = '0;
				if (kind_q == OP_XFER) begin
					hdr_q = r.request_header;
					wdata_q = r.write_data;
					tries_left = (r.retry_limit != 8'd0) ? r.retry_limit : 8'd1;
					enter(PH_HEADER);
				end else begin
					hdr_q = IDCODE_REQ;
					wdata_q = '0;
					tries_left = 8'd1;
					enter(PH_ONES_A);
				end
			end
			bc = bit_idx;
			o.clock_pulse = 1'b1;
			o.busy_res = 1'b1;
			case (seq_phase)
				PH_ONES_A: begin
					o.swdio_out = 1'b1;
					o.swdio_drive = 1'b1;
					if (span_done(LEN_ONES)) begin
						if (kind_q == OP_LINE_RESET) begin
							enter(PH_ZEROS);
						end else begin
							shreg = {16'h0, (kind_q == OP_CONNECT) ? SEL_TO_SWD : SEL_TO_JTAG};
							enter(PH_SELECT);
						end
					end
				end
				PH_SELECT: begin
					o.swdio_out = shreg[bc[3:0]];
					o.swdio_drive = 1'b1;
					if (span_done(LEN_SELECT)) begin
						if (kind_q == OP_CONNECT) begin
							kind_q = OP_LINE_RESET;
							enter(PH_ONES_A);
						end else begin
							enter(PH_ONES_B);
						end
					end
				end
				PH_ZEROS: begin
					o.swdio_drive = 1'b1;
					if (span_done(LEN_ZEROS))
						enter(PH_HEADER);
				end
				PH_ONES_B: begin
					o.swdio_out = 1'b1;
					o.swdio_drive = 1'b1;
					if (span_done(LEN_ONES))
						finish_cmd(ST_OK);
				end
				PH_HEADER: begin
					o.swdio_out = hdr_q[bc[2:0]];
					o.swdio_drive = 1'b1;
					if (span_done(LEN_HEADER))
						enter(PH_ACK);
				end
				PH_ACK: begin
					if (bc == 6'd0)
						ack_q = '0;
					else
						ack_q = ack_q | (3'(r.swdio_sample) << (bc - 6'd1));
					if (span_done(LEN_ACK)) begin
						if (ack_q == ACK_OK) begin
							if (hdr_q[2]) begin
								shreg = '0;
								enter(PH_RDATA);
							end else begin
								enter(PH_TURN);
							end
						end else if (ack_q == ACK_WAIT || ack_q == ACK_FAULT) begin
							enter(PH_TURN);
						end else begin
							enter(PH_DRAIN);
						end
					end
				end
				PH_RDATA: begin
					shreg = shreg | (32'(r.swdio_sample) << bc[4:0]);
					if (span_done(LEN_DATA))
						enter(PH_RPAR);
				end
				PH_RPAR: begin
					if (bc == 6'd0)
						ack_q = (r.swdio_sample ^ (^shreg)) ? 3'd0 : ACK_OK;
					if (span_done(LEN_RPAR)) begin
						rdata_q = shreg;
						finish_cmd((ack_q == ACK_OK) ? ST_OK : ST_PARITY);
					end
				end
				PH_TURN: begin
					if (span_done(LEN_TURN)) begin
						if (ack_q == ACK_OK)
							enter(PH_WDATA);
						else
							end_attempt((ack_q == ACK_WAIT) ? ST_WAIT : ST_FAULT);
					end
				end
				PH_WDATA: begin
					o.swdio_out = wdata_q[bc[4:0]];
					o.swdio_drive = 1'b1;
					if (span_done(LEN_DATA))
						enter(PH_WPAR);
				end
				PH_WPAR: begin
					o.swdio_out = (bc == 6'd0) ? ^wdata_q : 1'b0;
					o.swdio_drive = 1'b1;
					if (span_done(LEN_WPAR))
						finish_cmd(ST_OK);
				end
				PH_DRAIN: begin
					if (span_done(LEN_DRAIN))
						end_attempt(ST_NOACK);
				end
				default: begin
					finish_cmd(ST_NOACK);
				end
			endcase
			o.done_res = fin;
			o.status = fin ? fin_st : ST_OK;
			o.read_data = fin ? rdata_q : 32'h0;
			return o;
		endfunction

		function void note_request(swdh_in_t r);
			line_results_due.push_back(advance_sequencer(r));
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %h got %h", $time, name, want, got);
			end
		endfunction

		function void check_result(swdh_out_t got);
			swdh_out_t want;
			if (line_results_due.size() == 0) begin
				errors++;
				$display("%0t: result with none due, expected none got %h", $time, got);
				return;
			end
			want = line_results_due.pop_front();
			compare_field("swdio_out", want.swdio_out, got.swdio_out);
			compare_field("swdio_drive", want.swdio_drive, got.swdio_drive);
			compare_field("clock_pulse", want.clock_pulse, got.clock_pulse);
			compare_field("busy_res", want.busy_res, got.busy_res);
			compare_field("done_res", want.done_res, got.done_res);
			compare_field("status", want.status, got.status);
			compare_field("read_data", want.read_data, got.read_data);
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      period_valid;
	logic      period_stall;
	swdh_in_t  period;
	logic      result_valid;
	logic      result_stall = 1'b0;
	swdh_out_t result;

	swd_period_scoreboard sb;

	logic        ack_force_en = 1'b0;
	logic [2:0]  ack_force = ACK_OK;
	logic [2:0]  ack_code = ACK_OK;
	logic [31:0] target_word = '0;
	int unsigned bad_par_pct = 0;
	int unsigned noise_pct = 0;
	int unsigned busy_cmd_pct = 20;
	int unsigned calm_left = 0;
	int unsigned stall_left = 0;
	logic        stall_on = 1'b0;
	int unsigned quiet = 0;
	int unsigned sent_items = 0;

	swd_host_transaction_engine_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.period_valid(period_valid),
		.period_stall(period_stall),
		.period(period),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #10 clk = ~clk;

	always @(negedge clk) begin
		if (stall_left == 0) begin
			if ($urandom_range(0, 1) == 0) begin
				stall_on = 1'b0;
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
				                                          : $urandom_range(1, 8);
			end else begin
				stall_on = 1'b1;
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				                                          : $urandom_range(1, 3);
			end
		end
		stall_left--;
		result_stall <= stall_on;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
	end

	always @(posedge clk) begin
		if (!arst_n || (period_valid && !period_stall) || (result_valid && !result_stall)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic int unsigned draw_gap();
		int unsigned roll;
		if (calm_left != 0) begin
			calm_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			calm_left = $urandom_range(50, 300);
			return 0;
		end
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [2:0] draw_ack();
		int unsigned roll;
		logic [2:0]  odd;
		if (ack_force_en)
			return ack_force;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return ACK_OK;
		if (roll < 82)
			return ACK_WAIT;
		if (roll < 90)
			return ACK_FAULT;
		odd = 3'($urandom_range(0, 7));
		while (odd == ACK_OK || odd == ACK_WAIT || odd == ACK_FAULT)
			odd = 3'($urandom_range(0, 7));
		return odd;
	endfunction

	function automatic logic [31:0] draw_word();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// answer as the target from the state the next request will meet
	function automatic logic target_swdio();
		if ($urandom_range(0, 99) < noise_pct)
			return 1'($urandom_range(0, 1));
		case (sb.seq_phase)
			PH_ACK: begin
				if (sb.bit_idx == 6'd0)
					return 1'($urandom_range(0, 1));
				if (sb.bit_idx == 6'd1)
					ack_code = draw_ack();
				return ack_code[sb.bit_idx - 6'd1];
			end
			PH_RDATA: begin
				if (sb.bit_idx == 6'd0)
					target_word = draw_word();
				return target_word[sb.bit_idx[4:0]];
			end
			PH_RPAR: begin
				if (sb.bit_idx == 6'd0)
					return (^target_word) ^ ($urandom_range(0, 99) < bad_par_pct);
				return 1'($urandom_range(0, 1));
			end
			default: return 1'($urandom_range(0, 1));
		endcase
	endfunction

	function automatic swdh_in_t random_request(int unsigned cmd_pct);
		swdh_in_t p;
		p.cmd_valid = ($urandom_range(0, 99) < cmd_pct);
		p.opcode = 2'($urandom_range(0, 3));
		p.request_header = 8'($urandom);
		p.write_data = $urandom;
		p.retry_limit = 8'($urandom);
		p.swdio_sample = 1'b0;
		return p;
	endfunction

	task automatic send_period(input swdh_in_t p);
		int unsigned gap;
		gap = draw_gap();
		repeat (gap) begin
			@(negedge clk);
			period_valid <= 1'b0;
		end
		@(negedge clk);
		p.swdio_sample = target_swdio();
		period <= p;
		period_valid <= 1'b1;
		do @(posedge clk); while (period_stall !== 1'b0);
		sb.note_request(p);
		sent_items++;
	endtask

	task automatic run_command(input logic [1:0] op, input logic [7:0] hdr,
	                           input logic [31:0] wd, input logic [7:0] lim);
		swdh_in_t p;
		p.cmd_valid = 1'b1;
		p.opcode = op;
		p.request_header = hdr;
		p.write_data = wd;
		p.retry_limit = lim;
		p.swdio_sample = 1'b0;
		send_period(p);
		while (sb.seq_phase != PH_IDLE)
			send_period(random_request(busy_cmd_pct));
		repeat ($urandom_range(0, 2))
			send_period(random_request(0));
	endtask

	task automatic wait_drain();
		@(negedge clk);
		period_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic forced_xfer(input logic [2:0] ack, input logic [7:0] hdr,
	                           input logic [31:0] wd, input logic [7:0] lim);
		ack_force_en = 1'b1;
		ack_force = ack;
		run_command(OP_XFER, hdr, wd, lim);
		ack_force_en = 1'b0;
	endtask

	initial begin
		swdh_in_t    quiet_req;
		int unsigned roll;
		logic [1:0]  op;
		logic [7:0]  lim;
		sb = new();
		arst_n = 1'b0;
		period_valid = 1'b0;
		period = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// idle periods with every field set but no command
		quiet_req = '1;
		quiet_req.cmd_valid = 1'b0;
		repeat (3) send_period(quiet_req);

		forced_xfer(ACK_OK, 8'h00, 32'h0000_0000, 8'd0);
		forced_xfer(ACK_OK, 8'hFB, 32'hFFFF_FFFF, 8'd255);
		forced_xfer(ACK_OK, 8'hFF, 32'h0, 8'd1);
		bad_par_pct = 100;
		forced_xfer(ACK_OK, 8'h04, 32'h0, 8'd1);
		bad_par_pct = 0;
		forced_xfer(ACK_WAIT, 8'hA5, 32'h1234_5678, 8'd0);
		forced_xfer(ACK_WAIT, 8'h81, 32'h0, 8'd3);
		forced_xfer(ACK_FAULT, 8'h8D, 32'h0, 8'd5);
		forced_xfer(3'd0, 8'h87, 32'h0, 8'd2);
		ack_force_en = 1'b1;
		ack_force = ACK_OK;
		busy_cmd_pct = 100;
		run_command(OP_CONNECT, 8'h00, 32'h0, 8'd0);
		run_command(OP_DISCONNECT, 8'h00, 32'h0, 8'd0);
		busy_cmd_pct = 20;
		ack_force_en = 1'b0;
		wait_drain();

		bad_par_pct = 10;
		while (sent_items < ITEM_TARGET) begin
			roll = $urandom_range(0, 99);
			if (roll < 85)
				op = OP_XFER;
			else if (roll < 92)
				op = OP_LINE_RESET;
			else if (roll < 96)
				op = OP_CONNECT;
			else
				op = OP_DISCONNECT;
			roll = $urandom_range(0, 99);
			if (roll < 30)
				lim = 8'd0;
			else if (roll < 80)
				lim = 8'($urandom_range(1, 4));
			else if (roll < 95)
				lim = 8'($urandom_range(5, 20));
			else
				lim = 8'($urandom);
			noise_pct = ($urandom_range(0, 19) == 0) ? 100 : 2;
			run_command(op, 8'($urandom), draw_word(), lim);
			if ($urandom_range(0, 49) == 0)
				wait_drain();
		end

		wait_drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
